// ===== hw/rtl/skb_pkg.sv =====
// Shared types, constants and lookup functions for the station-keeping block.
// No dependencies; used by skb_ctrl, skb_dp and the top level.
package skb_pkg;

  localparam int HIST_DEPTH      = 64;
  localparam int HIST_AW         = $clog2(HIST_DEPTH);
  localparam int HIST_CW         = $clog2(HIST_DEPTH + 1);
  localparam int SWING_TIME_MS   = 0;
  localparam int WINDOW_MS       = 10000;
  localparam int MIN_SPAN_MS     = 5000;
  localparam int CORDIC_STEPS    = 24;
  localparam int CORDIC_PRESHIFT = 28;
  localparam int SQRT_STEPS      = 32;
  localparam int DIV_STEPS       = 16;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOPOS     = 2'd1;
  localparam logic [1:0] ST_NOSTATION = 2'd2;
  localparam logic [1:0] ST_IDLE      = 2'd3;

  // station modes
  localparam logic [1:0] MODE_FIXED  = 2'd1;
  localparam logic [1:0] MODE_CENTRE = 2'd2;

  // hibernation states
  localparam logic [1:0] HIB_DISABLED = 2'd0;
  localparam logic [1:0] HIB_SLEEP    = 2'd1;
  localparam logic [1:0] HIB_SEEK     = 2'd2;

  // transit states
  localparam logic [1:0] TR_IDLE       = 2'd0;
  localparam logic [1:0] TR_WAIT_START = 2'd1;
  localparam logic [1:0] TR_STARTED    = 2'd2;
  localparam logic [1:0] TR_ENDED      = 2'd3;

  // history trend verdicts
  localparam logic [1:0] TRD_NONE    = 2'd0;
  localparam logic [1:0] TRD_CLOSER  = 2'd1;
  localparam logic [1:0] TRD_FARTHER = 2'd2;
  localparam logic [1:0] TRD_EQUAL   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_STATION_MODE = 3'd0;
  localparam logic [2:0] REG_FIXED_X      = 3'd1;
  localparam logic [2:0] REG_FIXED_Y      = 3'd2;
  localparam logic [2:0] REG_INNER        = 3'd3;
  localparam logic [2:0] REG_OUTER        = 3'd4;
  localparam logic [2:0] REG_RAMP         = 3'd5;
  localparam logic [2:0] REG_TRANSIT      = 3'd6;
  localparam logic [2:0] REG_HIB_RADIUS   = 3'd7;

  typedef struct packed {
    logic       load;
    logic       pre;
    logic       dxy;
    logic       m0;
    logic       m1;
    logic       m2;
    logic       sq_init;
    logic       sq_step;
    logic       rnd;
    logic       push;
    logic       scan;
    logic       spd0;
    logic       tr0;
    logic       tr1;
    logic       hib;
    logic       spd1;
    logic       div_mul;
    logic       div_init;
    logic       div_step;
    logic       cord_init;
    logic       cord_step;
    logic       cord_fin;
    logic       out_load;
    logic [4:0] step;
  } skb_cmd_t;

  typedef struct packed {
    logic kind;
    logic pos_valid;
    logic changed;
    logic known;
    logic scan_done;
    logic need_div;
  } skb_sts_t;

  // atan(2^-i) in 0.01 degree / 1024
  function automatic logic signed [31:0] atan_lut(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd4608000;
      5'd1:  v = 32'sd2720261;
      5'd2:  v = 32'sd1437311;
      5'd3:  v = 32'sd729602;
      5'd4:  v = 32'sd366217;
      5'd5:  v = 32'sd183287;
      5'd6:  v = 32'sd91666;
      5'd7:  v = 32'sd45836;
      5'd8:  v = 32'sd22918;
      5'd9:  v = 32'sd11459;
      5'd10: v = 32'sd5730;
      5'd11: v = 32'sd2865;
      5'd12: v = 32'sd1432;
      5'd13: v = 32'sd716;
      5'd14: v = 32'sd358;
      5'd15: v = 32'sd179;
      5'd16: v = 32'sd90;
      5'd17: v = 32'sd45;
      5'd18: v = 32'sd22;
      5'd19: v = 32'sd11;
      5'd20: v = 32'sd6;
      5'd21: v = 32'sd3;
      5'd22: v = 32'sd1;
      5'd23: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/skb_ctrl.sv =====
// Sequencer for the station-keeping block: handshakes, step order, loop counts.
// Depends on skb_pkg; drives skb_dp through skb_cmd_t.
module skb_ctrl import skb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  skb_sts_t sts,
  output skb_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PRE  = 5'd1;
  localparam logic [4:0] S_DXY  = 5'd2;
  localparam logic [4:0] S_M0   = 5'd3;
  localparam logic [4:0] S_M1   = 5'd4;
  localparam logic [4:0] S_M2   = 5'd5;
  localparam logic [4:0] S_SQ0  = 5'd6;
  localparam logic [4:0] S_SQ   = 5'd7;
  localparam logic [4:0] S_RND  = 5'd8;
  localparam logic [4:0] S_PUSH = 5'd9;
  localparam logic [4:0] S_SCAN = 5'd10;
  localparam logic [4:0] S_SPD0 = 5'd11;
  localparam logic [4:0] S_TR0  = 5'd12;
  localparam logic [4:0] S_TR1  = 5'd13;
  localparam logic [4:0] S_HIB  = 5'd14;
  localparam logic [4:0] S_SPD1 = 5'd15;
  localparam logic [4:0] S_DVM  = 5'd16;
  localparam logic [4:0] S_DV0  = 5'd17;
  localparam logic [4:0] S_DV   = 5'd18;
  localparam logic [4:0] S_CI   = 5'd19;
  localparam logic [4:0] S_CS   = 5'd20;
  localparam logic [4:0] S_CF   = 5'd21;
  localparam logic [4:0] S_DONE = 5'd22;

  logic [4:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_PRE;
      S_PRE: begin
        if (sts.kind || !sts.pos_valid) state_nxt = S_DONE;
        else state_nxt = S_DXY;
      end
      S_DXY:  state_nxt = sts.changed ? S_SPD0 : S_M0;
      S_M0:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_SQ0;
      S_SQ0:  state_nxt = S_SQ;
      S_SQ:   if (cnt_r == 5'(SQRT_STEPS - 1)) state_nxt = S_RND;
      S_RND:  state_nxt = S_PUSH;
      S_PUSH: state_nxt = S_SCAN;
      S_SCAN: if (sts.scan_done) state_nxt = sts.known ? S_SPD0 : S_DONE;
      S_SPD0: state_nxt = S_TR0;
      S_TR0:  state_nxt = S_TR1;
      S_TR1:  state_nxt = S_HIB;
      S_HIB:  state_nxt = S_SPD1;
      S_SPD1: state_nxt = sts.need_div ? S_DVM : S_CI;
      S_DVM:  state_nxt = S_DV0;
      S_DV0:  state_nxt = S_DV;
      S_DV:   if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = S_CI;
      S_CI:   state_nxt = S_CS;
      S_CS:   if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = S_CF;
      S_CF:   state_nxt = S_DONE;
      S_DONE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // loop counter restarts on every state change
  assign cnt_nxt = (state_nxt != state_r) ? 5'd0 : cnt_r + 5'd1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (state_r == S_DONE && slot_free) out_valid_nxt = 1'b1;
  end

  always_comb begin
    cmd           = '0;
    cmd.step      = cnt_r;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.pre       = (state_r == S_PRE);
    cmd.dxy       = (state_r == S_DXY);
    cmd.m0        = (state_r == S_M0);
    cmd.m1        = (state_r == S_M1);
    cmd.m2        = (state_r == S_M2);
    cmd.sq_init   = (state_r == S_SQ0);
    cmd.sq_step   = (state_r == S_SQ);
    cmd.rnd       = (state_r == S_RND);
    cmd.push      = (state_r == S_PUSH);
    cmd.scan      = (state_r == S_SCAN);
    cmd.spd0      = (state_r == S_SPD0);
    cmd.tr0       = (state_r == S_TR0);
    cmd.tr1       = (state_r == S_TR1);
    cmd.hib       = (state_r == S_HIB);
    cmd.spd1      = (state_r == S_SPD1);
    cmd.div_mul   = (state_r == S_DVM);
    cmd.div_init  = (state_r == S_DV0);
    cmd.div_step  = (state_r == S_DV);
    cmd.cord_init = (state_r == S_CI);
    cmd.cord_step = (state_r == S_CS);
    cmd.cord_fin  = (state_r == S_CF);
    cmd.out_load  = (state_r == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_PRE)
    else $error("accepted item did not start processing");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && !out_ready |=> state_r == S_DONE && out_valid_r)
    else $error("result overwrote an untaken result");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CS |-> cnt_r < 5'(CORDIC_STEPS))
    else $error("cordic step index out of range");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise out_valid");

endmodule

// ===== hw/rtl/skb_dp.sv =====
// Datapath: config registers, station state, history RAM, shared multiplier,
// iterative square root, divider and CORDIC. Depends on skb_pkg.
module skb_dp import skb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  skb_cmd_t           cmd,
  output skb_sts_t           sts,
  input  logic               in_kind,
  input  logic [31:0]        in_time_ms,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic               in_pos_valid,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output logic [1:0]         out_status,
  output logic [15:0]        out_desired_speed,
  output logic [15:0]        out_bearing,
  output logic [31:0]        out_distance,
  output logic [1:0]         out_hiber_mode,
  output logic signed [31:0] out_station_x_out,
  output logic signed [31:0] out_station_y_out
);

  // latched item
  logic               kind_r, pv_r;
  logic [31:0]        t_r;
  logic signed [31:0] px_r, py_r;

  // configuration
  logic [1:0]         mode_r;
  logic signed [31:0] fx_r, fy_r;
  logic [31:0]        inner_r, outer_r, hibr_r;
  logic [15:0]        ramp_r, transit_r;

  // persistent state
  logic signed [31:0]  stx_r, sty_r;
  logic                known_r, cpend_r, mvalid_r;
  logic [31:0]         mtime_r, ldist_r;
  logic [1:0]          hib_r, trs_r;
  logic [HIST_AW-1:0]  head_r;
  logic [HIST_CW-1:0]  count_r;

  // work registers
  logic               changed_r, dxn_r, dyn_r;
  logic [31:0]        ax_r, ay_r;
  logic [63:0]        prod_r;
  logic [64:0]        acc_r;
  logic [63:0]        rad_r;
  logic [33:0]        srem_r;
  logic [31:0]        root_r;
  logic [HIST_CW-1:0] scan_i_r, drop_r;
  logic               spend_r;
  logic [63:0]        nent_r;
  logic [1:0]         trend_r;
  logic [31:0]        drem_r;
  logic [15:0]        dnum_r, quo_r;
  logic signed [63:0] cx_r, cy_r;
  logic signed [31:0] cz_r;
  logic               csw_r, czero_r, cbz_r, cbeq_r;
  logic [1:0]         res_status_r;
  logic [15:0]        res_speed_r, res_bear_r;

  // history RAM: {time, distance}
  logic [63:0]        hmem [HIST_DEPTH];
  logic [HIST_AW-1:0] rd_addr;
  logic [63:0]        rd_data_r;

  always_comb begin
    if (cmd.tr0)       rd_addr = head_r - count_r[HIST_AW-1:0];
    else if (cmd.scan) rd_addr = head_r - scan_i_r[HIST_AW-1:0];
    else               rd_addr = head_r - HIST_AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.push) hmem[head_r] <= {t_r, ldist_r};
    rd_data_r <= hmem[rd_addr];
  end

  // ---------------- combinational helpers ----------------
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] ddiff, dvsr;

  assign ddiff = ldist_r - inner_r;
  assign dvsr  = outer_r - inner_r;

  always_comb begin
    mul_a = ax_r;
    mul_b = ax_r;
    if (cmd.m1) begin
      mul_a = ay_r;
      mul_b = ay_r;
    end else if (cmd.div_mul) begin
      mul_a = ddiff;
      mul_b = {16'd0, ramp_r};
    end
  end
  assign mul_p = mul_a * mul_b;

  // station update on a fix
  logic        ch;
  logic [31:0] mt_eff;
  assign mt_eff = mvalid_r ? mtime_r : t_r;
  assign ch = !kind_r && pv_r && cpend_r && (mode_r == MODE_CENTRE || mode_r == MODE_FIXED);

  // offsets to station
  logic signed [32:0] dxs, dys;
  assign dxs = {stx_r[31], stx_r} - {px_r[31], px_r};
  assign dys = {sty_r[31], sty_r} - {py_r[31], py_r};

  // square root step
  logic [35:0] rem4, trial;
  logic        rup;
  logic [32:0] rr;
  assign rem4  = {srem_r, rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign rup   = srem_r > {2'b00, root_r};
  assign rr    = {1'b0, root_r} + {32'd0, rup};

  // window scan
  logic sc_old, scan_done;
  assign sc_old = {1'b0, t_r} > ({1'b0, rd_data_r[63:32]} + 33'(WINDOW_MS));
  assign scan_done = (scan_i_r > count_r) && !spend_r;

  // trend of newest against oldest entry
  logic [1:0] trend_nxt;
  always_comb begin
    if (count_r == '0)
      trend_nxt = TRD_NONE;
    else if ({1'b0, nent_r[63:32]} <= ({1'b0, rd_data_r[63:32]} + 33'(MIN_SPAN_MS)))
      trend_nxt = TRD_NONE;
    else if (nent_r[31:0] == rd_data_r[31:0])
      trend_nxt = TRD_EQUAL;
    else if (nent_r[31:0] < rd_data_r[31:0])
      trend_nxt = TRD_CLOSER;
    else
      trend_nxt = TRD_FARTHER;
  end

  // hibernation update
  logic [1:0] hib_nxt, trs_nxt;
  logic       hclr;
  always_comb begin
    hib_nxt = hib_r;
    trs_nxt = trs_r;
    hclr    = 1'b0;
    if (hib_r != HIB_DISABLED) begin
      if (trs_r == TR_WAIT_START) begin
        if (ldist_r <= hibr_r && trend_r != TRD_NONE && trend_r != TRD_FARTHER) begin
          hclr    = 1'b1;
          trs_nxt = TR_STARTED;
        end
      end else if (trs_r == TR_STARTED) begin
        if (trend_r == TRD_FARTHER || trend_r == TRD_EQUAL) trs_nxt = TR_ENDED;
      end
      if (hib_r == HIB_SLEEP) begin
        if (ldist_r > hibr_r) begin
          hib_nxt = HIB_SEEK;
          hclr    = 1'b1;
          trs_nxt = TR_WAIT_START;
        end
      end else if (hib_r == HIB_SEEK) begin
        if (ldist_r <= inner_r || (trs_nxt == TR_ENDED && ldist_r <= hibr_r)) begin
          hib_nxt = HIB_SLEEP;
          trs_nxt = TR_IDLE;
          hclr    = 1'b1;
        end
      end
    end
  end

  logic spd_zero, need_div;
  assign spd_zero = (hib_r == HIB_SLEEP) || (ldist_r <= inner_r);
  assign need_div = !spd_zero && (ldist_r < outer_r);

  // divider step
  logic [32:0] drem2;
  logic        dge;
  assign drem2 = {drem_r, dnum_r[15]};
  assign dge   = drem2 >= {1'b0, dvsr};

  // cordic
  logic               cord_ge;
  logic [31:0]        ca, cb;
  logic signed [63:0] xs, ys;
  logic signed [31:0] at;
  assign cord_ge = ay_r >= ax_r;
  assign ca = cord_ge ? ay_r : ax_r;
  assign cb = cord_ge ? ax_r : ay_r;
  assign xs = cx_r >>> cmd.step;
  assign ys = cy_r >>> cmd.step;
  assign at = atan_lut(cmd.step);

  logic signed [31:0] zc;
  logic [31:0]        zr;
  logic [12:0]        oct;
  logic [13:0]        q;
  logic [16:0]        bsum;
  logic [15:0]        bear;
  always_comb begin
    zc = (cz_r < 0) ? 32'sd0 : cz_r;
    zr = 32'(zc + 32'sd512) >> 10;
    oct = (zr > 32'd4500) ? 13'd4500 : zr[12:0];
    if (cbz_r) oct = 13'd0;
    else if (cbeq_r) oct = 13'd4500;
    q = csw_r ? 14'(14'd9000 - {1'b0, oct}) : {1'b0, oct};
    if (!dxn_r) bsum = dyn_r ? 17'(17'd18000 - {3'b0, q}) : {3'b0, q};
    else bsum = dyn_r ? 17'(17'd18000 + {3'b0, q}) : 17'(17'd36000 - {3'b0, q});
    bear = (czero_r || bsum >= 17'd36000) ? 16'd0 : bsum[15:0];
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      t_r    <= in_time_ms;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      pv_r   <= in_pos_valid;
    end
    if (cmd.pre) changed_r <= ch;
    if (cmd.dxy) begin
      dxn_r <= dxs[32];
      dyn_r <= dys[32];
      ax_r  <= dxs[32] ? 32'(-dxs) : dxs[31:0];
      ay_r  <= dys[32] ? 32'(-dys) : dys[31:0];
    end
    if (cmd.m0 || cmd.m1 || cmd.div_mul) prod_r <= mul_p;
    if (cmd.m1) acc_r <= {1'b0, prod_r};
    if (cmd.m2) acc_r <= acc_r + {1'b0, prod_r};
    if (cmd.sq_init) begin
      rad_r  <= acc_r[63:0];
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd.sq_step) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (rem4 >= trial) begin
        srem_r <= 34'(rem4 - trial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        srem_r <= rem4[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
    if (cmd.tr0) nent_r <= rd_data_r;
    if (cmd.tr1) trend_r <= trend_nxt;
    if (cmd.div_init) begin
      drem_r <= prod_r[47:16];
      dnum_r <= prod_r[15:0];
      quo_r  <= '0;
    end
    if (cmd.div_step) begin
      drem_r <= dge ? 32'(drem2 - {1'b0, dvsr}) : drem2[31:0];
      dnum_r <= {dnum_r[14:0], 1'b0};
      quo_r  <= {quo_r[14:0], dge};
    end
    if (cmd.cord_init) begin
      cx_r    <= 64'({ca, 28'd0});
      cy_r    <= 64'({cb, 28'd0});
      cz_r    <= '0;
      csw_r   <= !cord_ge;
      czero_r <= (ax_r == '0) && (ay_r == '0);
      cbz_r   <= (cb == '0);
      cbeq_r  <= (ca == cb);
    end
    if (cmd.cord_step) begin
      if (cy_r >= 0) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end
    end
    // result fields
    if (cmd.pre) begin
      res_speed_r <= '0;
      res_bear_r  <= '0;
      if (kind_r)     res_status_r <= ST_IDLE;
      else if (!pv_r) res_status_r <= ST_NOPOS;
      else            res_status_r <= ST_OK;
    end
    if (cmd.scan && scan_done && !known_r) res_status_r <= ST_NOSTATION;
    if (cmd.spd1) res_speed_r <= spd_zero ? 16'd0 : transit_r;
    if (cmd.div_step) res_speed_r <= {quo_r[14:0], dge};
    if (cmd.cord_fin) res_bear_r <= bear;
    if (cmd.out_load) begin
      out_status        <= res_status_r;
      out_desired_speed <= res_speed_r;
      out_bearing       <= res_bear_r;
      out_distance      <= ldist_r;
      out_hiber_mode    <= hib_r;
      out_station_x_out <= stx_r;
      out_station_y_out <= sty_r;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 2'd0;
      fx_r      <= '0;
      fy_r      <= '0;
      inner_r   <= 32'd400;
      outer_r   <= 32'd1500;
      ramp_r    <= 16'd1200;
      transit_r <= 16'd2500;
      hibr_r    <= '0;
      stx_r     <= '0;
      sty_r     <= '0;
      known_r   <= 1'b0;
      cpend_r   <= 1'b1;
      mvalid_r  <= 1'b0;
      mtime_r   <= '0;
      ldist_r   <= '0;
      hib_r     <= HIB_DISABLED;
      trs_r     <= TR_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      scan_i_r  <= '0;
      drop_r    <= '0;
      spend_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STATION_MODE: begin
            mode_r  <= cfg_wdata[1:0];
            cpend_r <= 1'b1;
          end
          REG_FIXED_X: begin
            fx_r    <= cfg_wdata;
            cpend_r <= 1'b1;
          end
          REG_FIXED_Y: begin
            fy_r    <= cfg_wdata;
            cpend_r <= 1'b1;
          end
          REG_INNER: inner_r <= cfg_wdata;
          REG_OUTER: outer_r <= cfg_wdata;
          REG_RAMP: begin
            ramp_r <= cfg_wdata[15:0];
            if (transit_r < cfg_wdata[15:0]) transit_r <= cfg_wdata[15:0];
          end
          REG_TRANSIT: transit_r <= cfg_wdata[15:0];
          REG_HIB_RADIUS: begin
            hibr_r <= cfg_wdata;
            if (cfg_wdata == '0) hib_r <= HIB_DISABLED;
            else if (hib_r == HIB_DISABLED) hib_r <= HIB_SLEEP;
          end
          default: ;
        endcase
      end
      if (cmd.pre) begin
        if (kind_r) begin
          head_r   <= '0;
          count_r  <= '0;
          if (mode_r == MODE_CENTRE) cpend_r <= 1'b1;
          mvalid_r <= 1'b0;
          mtime_r  <= '0;
        end else begin
          if (!mvalid_r) begin
            mvalid_r <= 1'b1;
            mtime_r  <= t_r;
          end
          if (pv_r && cpend_r) begin
            if (mode_r == MODE_CENTRE) begin
              stx_r   <= px_r;
              sty_r   <= py_r;
              known_r <= 1'b1;
              if ({1'b0, t_r} >= ({1'b0, mt_eff} + 33'(SWING_TIME_MS))) cpend_r <= 1'b0;
            end else if (mode_r == MODE_FIXED) begin
              stx_r   <= fx_r;
              sty_r   <= fy_r;
              known_r <= 1'b1;
              cpend_r <= 1'b0;
            end
          end
          if (ch) begin
            if (hib_r != HIB_DISABLED) hib_r <= HIB_SLEEP;
            trs_r <= TR_IDLE;
          end
        end
      end
      if (cmd.rnd)
        ldist_r <= (acc_r[64] || rr >= 33'h0FFFFFFFF) ? 32'hFFFFFFFF : rr[31:0];
      if (cmd.push) begin
        head_r   <= head_r + HIST_AW'(1);
        if (count_r != HIST_CW'(HIST_DEPTH)) count_r <= count_r + HIST_CW'(1);
        scan_i_r <= HIST_CW'(1);
        drop_r   <= '0;
        spend_r  <= 1'b0;
      end
      if (cmd.scan) begin
        if (spend_r && sc_old) drop_r <= drop_r + HIST_CW'(1);
        if (scan_i_r <= count_r) begin
          spend_r  <= 1'b1;
          scan_i_r <= scan_i_r + HIST_CW'(1);
        end else begin
          spend_r <= 1'b0;
        end
        if (scan_done) count_r <= count_r - drop_r;
      end
      if (cmd.spd0 && inner_r > outer_r) outer_r <= inner_r;
      if (cmd.hib) begin
        hib_r <= hib_nxt;
        trs_r <= trs_nxt;
        if (hclr) begin
          head_r  <= '0;
          count_r <= '0;
        end
      end
    end
  end

  assign sts.kind      = kind_r;
  assign sts.pos_valid = pv_r;
  assign sts.changed   = changed_r;
  assign sts.known     = known_r;
  assign sts.scan_done = scan_done;
  assign sts.need_div  = need_div;

endmodule

// ===== hw/rtl/station_keep_speed_bearing_top.sv =====
// Station keeping: distance, bearing and desired speed toward a station point.
// An idle event or missing fix goes from decode straight to the result. A full fix runs the
// squares, square root, history push and a scan of every entry kept, then (if a station is
// known) trend, hibernation, speed (divide only inside the ramp) and bearing; a fix that
// takes a new centre goes straight to the speed steps. Throughput: one item at a time; the
// next item is taken in the cycle after the result is parked in the output register. Reset:
// synchronous active-low rst_n; config returns to defaults, history empty.
module station_keep_speed_bearing_top import skb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [31:0]        in_time_ms,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic               in_pos_valid,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_desired_speed,
  output logic [15:0]        out_bearing,
  output logic [31:0]        out_distance,
  output logic [1:0]         out_hiber_mode,
  output logic signed [31:0] out_station_x_out,
  output logic signed [31:0] out_station_y_out,
  // configuration writes, only while the block is idle
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  // The sequencer steps through: decode, offsets, squares (shared 32x32
  // multiplier), 32-step square root, history push and window scan,
  // trend reads, hibernation update, 16-step ramp divide, 24-step CORDIC.
  skb_cmd_t cmd;
  skb_sts_t sts;

  skb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath owns all config, station state and the history RAM
  skb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_time_ms        (in_time_ms),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_valid      (in_pos_valid),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_status        (out_status),
    .out_desired_speed (out_desired_speed),
    .out_bearing       (out_bearing),
    .out_distance      (out_distance),
    .out_hiber_mode    (out_hiber_mode),
    .out_station_x_out (out_station_x_out),
    .out_station_y_out (out_station_y_out)
  );

endmodule

// ===== bench/tb_station_keep_speed_bearing_top.sv =====
// Self-checking bench for station_keep_speed_bearing_top: directed and random fixes,
// checked against an in-bench fixed-point predictor. Depends on skb_pkg and the top level.
module tb_station_keep_speed_bearing_top;
  import skb_pkg::*;

  // one result transfer
  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        speed;
    logic [15:0]        bearing;
    logic [31:0]        distance;
    logic [1:0]         hiber;
    logic signed [31:0] stn_x;
    logic signed [31:0] stn_y;
  } guidance_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = 1'b0;
  logic [31:0]        in_time_ms = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic               in_pos_valid = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [15:0]        out_desired_speed;
  logic [15:0]        out_bearing;
  logic [31:0]        out_distance;
  logic [1:0]         out_hiber_mode;
  logic signed [31:0] out_station_x_out;
  logic signed [31:0] out_station_y_out;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  station_keep_speed_bearing_top u_dut (.*);

  initial forever #4 clk = ~clk;

  // expected results, oldest first
  guidance_t guidance_q[$];
  int        err_cnt = 0;
  int        checked_cnt = 0;
  int        sent_cnt = 0;
  bit        idle_on = 1'b1;   // random gaps on both sides
  int        hold_cycles = 0;  // long receiver hold-off, counted down by the receiver

  // ---------------------------------------------------------------------------
  // Predictor state: configuration copy and the block's own state
  // ---------------------------------------------------------------------------
  logic [1:0]         p_mode;
  logic [31:0]        p_fix_x, p_fix_y, p_inner, p_outer, p_hib_radius;
  logic [15:0]        p_ramp, p_transit;
  logic signed [31:0] p_stn_x, p_stn_y;
  logic               p_known, p_pending, p_mark_valid;
  logic [31:0]        p_mark_time, p_last_dist;
  logic [1:0]         p_hib, p_tr;
  logic [31:0]        hist_dist[HIST_DEPTH];
  logic [31:0]        hist_time[HIST_DEPTH];
  int                 hist_head, hist_cnt;

  function automatic longint u2l(logic [31:0] v);
    return longint'({32'd0, v});
  endfunction

  task automatic reset_predictor();
    p_mode = 0; p_fix_x = 0; p_fix_y = 0; p_inner = 400; p_outer = 1500;
    p_ramp = 1200; p_transit = 2500; p_hib_radius = 0;
    p_stn_x = 0; p_stn_y = 0; p_known = 0; p_pending = 1; p_mark_valid = 0;
    p_mark_time = 0; p_last_dist = 0; p_hib = HIB_DISABLED; p_tr = TR_IDLE;
    hist_head = 0; hist_cnt = 0;
  endtask

  task automatic apply_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_STATION_MODE: begin p_mode = v[1:0]; p_pending = 1; end
      REG_FIXED_X:      begin p_fix_x = v; p_pending = 1; end
      REG_FIXED_Y:      begin p_fix_y = v; p_pending = 1; end
      REG_INNER:        p_inner = v;
      REG_OUTER:        p_outer = v;
      REG_RAMP: begin
        p_ramp = v[15:0];
        if (p_transit < p_ramp) p_transit = p_ramp;
      end
      REG_TRANSIT:      p_transit = v[15:0];
      REG_HIB_RADIUS: begin
        p_hib_radius = v;
        if (v == 0) p_hib = HIB_DISABLED;
        else if (p_hib == HIB_DISABLED) p_hib = HIB_SLEEP;
      end
      default: ;
    endcase
  endtask

  function automatic int hist_slot(int back);
    return (hist_head + HIST_DEPTH - back) % HIST_DEPTH;
  endfunction

  task automatic hist_push(logic [31:0] t, logic [31:0] d);
    int drop;
    drop = 0;
    hist_dist[hist_head] = d;
    hist_time[hist_head] = t;
    hist_head = (hist_head + 1) % HIST_DEPTH;
    if (hist_cnt < HIST_DEPTH) hist_cnt++;
    for (int i = 1; i <= hist_cnt; i++)
      if (u2l(t) - u2l(hist_time[hist_slot(i)]) > WINDOW_MS) drop++;
    hist_cnt -= drop;
  endtask

  function automatic logic [1:0] hist_trend();
    int o, n;
    if (hist_cnt == 0) return TRD_NONE;
    o = hist_slot(hist_cnt);
    n = hist_slot(1);
    if (u2l(hist_time[n]) - u2l(hist_time[o]) <= MIN_SPAN_MS) return TRD_NONE;
    if (hist_dist[n] == hist_dist[o]) return TRD_EQUAL;
    return (hist_dist[n] < hist_dist[o]) ? TRD_CLOSER : TRD_FARTHER;
  endfunction

  function automatic logic [31:0] range_of(logic [63:0] ax, logic [63:0] ay);
    logic [63:0] s1, s2, s, r, b;
    s1 = ax * ax;
    s2 = ay * ay;
    if (s1 > ~64'd0 - s2) return 32'hFFFF_FFFF;
    s = s1 + s2;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    // s now holds the remainder v - r*r
    if (s > r) r++;
    return (r >= 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  // atan(b/a) for a >= b, a > 0, in 0.01 degree
  function automatic logic [31:0] octant_deg(logic [63:0] a, logic [63:0] b);
    longint x, y, z, xs, ys, r;
    if (b == 0) return 0;
    if (b == a) return 4500;
    x = longint'(a << CORDIC_PRESHIFT);
    y = longint'(b << CORDIC_PRESHIFT);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(atan_lut(5'(i)));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_lut(5'(i)));
      end
    end
    if (z < 0) z = 0;
    r = (z + 512) >>> 10;
    return (r > 4500) ? 32'd4500 : 32'(r);
  endfunction

  function automatic logic [31:0] compass_of(longint dx, longint dy);
    logic [63:0] ax, ay;
    logic [31:0] q, b;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax == 0 && ay == 0) return 0;
    q = (ay >= ax) ? octant_deg(ay, ax) : 32'd9000 - octant_deg(ax, ay);
    if (dx >= 0) b = (dy >= 0) ? q : 32'd18000 - q;
    else         b = (dy < 0) ? 32'd18000 + q : 32'd36000 - q;
    return (b >= 36000) ? 32'd0 : b;
  endfunction

  task automatic step_hibernation(logic [31:0] d);
    logic [1:0] tv;
    if (p_hib == HIB_DISABLED) return;
    tv = hist_trend();
    if (p_tr == TR_WAIT_START) begin
      if (d <= p_hib_radius && (tv == TRD_CLOSER || tv == TRD_EQUAL)) begin
        hist_head = 0; hist_cnt = 0;
        p_tr = TR_STARTED;
      end
    end else if (p_tr == TR_STARTED) begin
      if (tv == TRD_FARTHER || tv == TRD_EQUAL) p_tr = TR_ENDED;
    end
    if (p_hib == HIB_SLEEP) begin
      if (d > p_hib_radius) begin
        p_hib = HIB_SEEK;
        hist_head = 0; hist_cnt = 0;
        p_tr = TR_WAIT_START;
      end
    end else if (p_hib == HIB_SEEK) begin
      if (d <= p_inner || (p_tr == TR_ENDED && d <= p_hib_radius)) begin
        p_hib = HIB_SLEEP;
        p_tr = TR_IDLE;
        hist_head = 0; hist_cnt = 0;
      end
    end
  endtask

  function automatic guidance_t pack_guidance(logic [1:0] st, logic [31:0] spd,
                                              logic [31:0] brg);
    guidance_t g;
    g.status = st; g.speed = spd[15:0]; g.bearing = brg[15:0];
    g.distance = p_last_dist; g.hiber = p_hib; g.stn_x = p_stn_x; g.stn_y = p_stn_y;
    return g;
  endfunction

  task automatic predict_guidance(logic kind, logic [31:0] t, logic signed [31:0] px,
                                  logic signed [31:0] py, logic pv, output guidance_t g);
    logic        changed;
    longint      dx, dy;
    logic [31:0] d, spd;
    changed = 0;
    if (kind) begin
      hist_head = 0; hist_cnt = 0;
      if (p_mode == MODE_CENTRE) p_pending = 1;
      p_mark_valid = 0; p_mark_time = 0;
      g = pack_guidance(ST_IDLE, 0, 0);
      return;
    end
    if (!p_mark_valid) begin
      p_mark_valid = 1; p_mark_time = t;
    end
    if (!pv) begin
      g = pack_guidance(ST_NOPOS, 0, 0);
      return;
    end
    if (p_pending) begin
      if (p_mode == MODE_CENTRE) begin
        p_stn_x = px; p_stn_y = py; p_known = 1; changed = 1;
        if (u2l(t) >= u2l(p_mark_time) + SWING_TIME_MS) p_pending = 0;
      end else if (p_mode == MODE_FIXED) begin
        p_stn_x = p_fix_x; p_stn_y = p_fix_y; p_known = 1; p_pending = 0; changed = 1;
      end
    end
    dx = longint'(p_stn_x) - longint'(px);
    dy = longint'(p_stn_y) - longint'(py);
    if (changed) begin
      // new centre: distance and history left as they were
      if (p_hib != HIB_DISABLED) p_hib = HIB_SLEEP;
      p_tr = TR_IDLE;
    end else begin
      p_last_dist = range_of((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
      hist_push(t, p_last_dist);
    end
    if (!p_known) begin
      g = pack_guidance(ST_NOSTATION, 0, 0);
      return;
    end
    if (p_inner > p_outer) p_outer = p_inner;
    step_hibernation(p_last_dist);
    d = p_last_dist;
    if (p_hib == HIB_SLEEP || d <= p_inner) spd = 0;
    else if (d < p_outer)
      spd = 32'((64'(d - p_inner) * 64'(p_ramp)) / 64'(p_outer - p_inner));
    else spd = p_transit;
    g = pack_guidance(ST_OK, spd, compass_of(dx, dy));
  endtask

  // ---------------------------------------------------------------------------
  // Driving: tasks are entered and left at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(logic kind, logic [31:0] t, logic signed [31:0] px,
                           logic signed [31:0] py, logic pv);
    guidance_t g;
    cfg_we <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_time_ms   <= t;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_pos_valid <= pv;
    do @(posedge clk); while (!in_ready);
    // transfer taken at this edge
    predict_guidance(kind, t, px, py, pv, g);
    guidance_q.push_back(g);
    sent_cnt++;
  endtask

  task automatic send_fix(logic [31:0] t, logic signed [31:0] px, logic signed [31:0] py);
    send_item(1'b0, t, px, py, 1'b1);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (guidance_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    apply_reg(idx, v);
  endtask

  task automatic write_reg_idle(logic [2:0] idx, logic [31:0] v);
    drain();
    write_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(logic [1:0] mode, logic [31:0] fx, logic [31:0] fy,
                       logic [31:0] inner, logic [31:0] outer, logic [15:0] transit,
                       logic [15:0] ramp, logic [31:0] hibr);
    drain();
    write_reg(REG_STATION_MODE, mode);
    write_reg(REG_FIXED_X, fx);
    write_reg(REG_FIXED_Y, fy);
    write_reg(REG_INNER, inner);
    write_reg(REG_OUTER, outer);
    write_reg(REG_TRANSIT, transit);
    write_reg(REG_RAMP, ramp);
    write_reg(REG_HIB_RADIUS, hibr);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result check, one process
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    guidance_t exp_g, got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_desired_speed, out_bearing, out_distance,
              out_hiber_mode, out_station_x_out, out_station_y_out};
      if (guidance_q.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, got);
        err_cnt++;
      end else begin
        exp_g = guidance_q.pop_front();
        checked_cnt++;
        if (got.status !== exp_g.status)
          $display("%0t: status exp %0d got %0d", $time, exp_g.status, got.status);
        if (got.speed !== exp_g.speed)
          $display("%0t: speed exp %0d got %0d", $time, exp_g.speed, got.speed);
        if (got.bearing !== exp_g.bearing)
          $display("%0t: bearing exp %0d got %0d", $time, exp_g.bearing, got.bearing);
        if (got.distance !== exp_g.distance)
          $display("%0t: distance exp %0d got %0d", $time, exp_g.distance, got.distance);
        if (got.hiber !== exp_g.hiber)
          $display("%0t: hiber exp %0d got %0d", $time, exp_g.hiber, got.hiber);
        if (got.stn_x !== exp_g.stn_x)
          $display("%0t: station_x exp %0d got %0d", $time, exp_g.stn_x, got.stn_x);
        if (got.stn_y !== exp_g.stn_y)
          $display("%0t: station_y exp %0d got %0d", $time, exp_g.stn_y, got.stn_y);
        if (got !== exp_g) err_cnt++;
      end
    end
    // ready: long hold-off first, then random stalls
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset defaults: no station, missing fix, idle event, extreme positions
  task automatic test_reset_defaults();
    send_fix(0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_item(1'b0, 100, 5, 5, 1'b0);
    send_item(1'b1, 200, 0, 0, 1'b1);
    send_fix(32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
  endtask

  // fixed station: every region of the speed curve and three of the four bearing quadrants
  task automatic test_fixed_station();
    setup(MODE_FIXED, 1000, -2000, 400, 1500, 3000, 1200, 0);
    send_fix(10, 1000, -2000);      // on the station: bearing 0
    send_fix(20, 1200, -2000);      // inside inner radius
    send_fix(30, 1000, -2800);      // ramp, north
    send_fix(40, 2000, -1000);      // ramp, diagonal a == b
    send_fix(50, -5000, -2000);     // transit, east
    send_fix(60, 4000, 3000);       // south-west quadrant
    send_fix(70, -3000, -9000);     // north-east quadrant
    send_fix(80, 1700, -2000);      // within the ramp
    send_fix(90, 2500, -2000);      // exactly at outer radius
    // saturated distance at opposite corners
    setup(MODE_FIXED, 32'h8000_0000, 32'h8000_0000, 1, 32'hFFFF_FFFF, 65535, 65535, 0);
    send_fix(100, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_fix(110, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_fix(120, 32'sh8000_0001, 32'sh8000_0000);
  endtask

  // outer below inner, minimum radii and speeds, station mode three
  task automatic test_radius_edges();
    setup(MODE_FIXED, 0, 0, 5000, 100, 1, 1, 0);
    send_fix(0, 4000, 0);
    send_fix(5, 6000, 0);
    setup(MODE_FIXED, 0, 0, 32'hFFFF_FFFF, 1, 100, 50, 0);
    send_fix(0, 100, 100);
    setup(2'd3, 0, 0, 1, 1, 10, 20, 0);
    send_fix(0, 50, 50);
  endtask

  // centre on activation, idle re-arms it, hibernation with a seek run
  task automatic test_centre_hibernation();
    logic [31:0] t;
    setup(MODE_CENTRE, 0, 0, 300, 1200, 2000, 900, 2000);
    send_fix(1000, 500, 700);       // centre taken
    t = 1000;
    for (int i = 0; i < 12; i++) begin
      t += 900;
      send_fix(t, 500 + i * 400, 700);   // drift out: sleep to seek
    end
    for (int i = 0; i < 12; i++) begin
      t += 900;
      send_fix(t, 5300 - i * 450, 700);  // come back
    end
    send_item(1'b1, t, 0, 0, 1'b1);
    send_fix(t + 10, -400, 900);    // new centre after idle
    write_reg_idle(REG_HIB_RADIUS, 0);
    send_fix(t + 20, 3000, 900);
  endtask

  // random trajectory around the station with noise, idle events and missing fixes
  task automatic run_trajectory(int n, logic signed [31:0] cx, logic signed [31:0] cy);
    logic [31:0] t;
    int          px, py, vx, vy, r;
    t  = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200000)
                                     : $urandom_range(0, 1000000);
    px = int'($urandom_range(0, 6000)) - 3000;
    py = int'($urandom_range(0, 6000)) - 3000;
    vx = int'($urandom_range(0, 400)) - 200;
    vy = int'($urandom_range(0, 400)) - 200;
    for (int i = 0; i < n; i++) begin
      t += $urandom_range(100, 1500);
      if ($urandom_range(0, 15) == 0) begin
        vx = int'($urandom_range(0, 400)) - 200;
        vy = int'($urandom_range(0, 400)) - 200;
      end
      if ($urandom_range(0, 30) == 0) begin vx = -vx; vy = -vy; end
      px += vx; py += vy;
      r = $urandom_range(0, 99);
      if (r < 4)       send_item(1'b1, t, $urandom, $urandom, $urandom_range(0, 1));
      else if (r < 9)  send_item(1'b0, t, $urandom, $urandom, 1'b0);
      else if (r < 12) send_item(1'b0, $urandom, $urandom, $urandom, 1'b1);
      else             send_fix(t, cx + px, cy + py);
    end
  endtask

  task automatic random_setup(output logic signed [31:0] cx, output logic signed [31:0] cy);
    logic [31:0] inner, outer, hibr;
    logic [1:0]  mode;
    mode = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                       : 2'($urandom_range(1, 2));
    cx = ($urandom_range(0, 4) == 0) ? $urandom : int'($urandom_range(0, 200000)) - 100000;
    cy = ($urandom_range(0, 4) == 0) ? $urandom : int'($urandom_range(0, 200000)) - 100000;
    inner = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32'hFFFF_FFFF)
                                        : $urandom_range(1, 1500);
    outer = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32'hFFFF_FFFF)
                                        : $urandom_range(1, 4000);
    case ($urandom_range(0, 3))
      0:       hibr = 0;
      1:       hibr = $urandom_range(1, 32'hFFFF_FFFF);
      default: hibr = $urandom_range(500, 4000);
    endcase
    setup(mode, cx, cy, inner, outer, $urandom_range(1, 65535), $urandom_range(1, 65535),
          hibr);
  endtask

  // receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_backpressure();
    logic signed [31:0] cx, cy;
    random_setup(cx, cy);
    hold_cycles = 800;
    run_trajectory(20, cx, cy);
    drain();
    repeat ($urandom_range(50, 200)) @(posedge clk);
    run_trajectory(10, cx, cy);
  endtask

  task automatic test_random();
    logic signed [31:0] cx, cy;
    for (int ph = 0; ph < 14; ph++) begin
      random_setup(cx, cy);
      run_trajectory(100, cx, cy);
    end
  endtask

  // steady stream with no gaps on either side
  task automatic test_no_idle();
    logic signed [31:0] cx, cy;
    random_setup(cx, cy);
    idle_on = 1'b0;
    run_trajectory(60, cx, cy);
  endtask

  initial begin
    reset_predictor();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_fixed_station();
    test_radius_edges();
    test_centre_hibernation();
    test_backpressure();
    test_random();
    test_no_idle();
    in_valid <= 1'b0;
    while (guidance_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (guidance_q.size() != 0) err_cnt++;
    $display("Sent %0d items, checked %0d results across fixed, centre and hibernation",
             sent_cnt, checked_cnt);
    $display("settings with random stalls and one long receiver hold-off; %0d mismatches",
             err_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // overall watchdog
  initial begin
    #40_000_000;
    $display("Timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== station_keep_speed_bearing_top.f =====
hw/rtl/skb_pkg.sv
hw/rtl/skb_ctrl.sv
hw/rtl/skb_dp.sv
hw/rtl/station_keep_speed_bearing_top.sv
bench/tb_station_keep_speed_bearing_top.sv
